@@ rtl/core/nla_pkg.sv @@
`timescale 1ns / 1ps
// shared types and constants of the notification led arbiter
// no dependencies; imported by every module of the block
package nla_pkg;

    localparam logic [2:0] OP_BACKLIGHT    = 3'd0;
    localparam logic [2:0] OP_BUTTONS      = 3'd1;
    localparam logic [2:0] OP_NOTIFICATION = 3'd2;
    localparam logic [2:0] OP_ATTENTION    = 3'd3;
    localparam logic [2:0] OP_BATTERY      = 3'd4;

    localparam int NUM_SOURCES = 4;
    localparam logic [1:0] SRC_BUTTONS      = 2'd0;
    localparam logic [1:0] SRC_ATTENTION    = 2'd1;
    localparam logic [1:0] SRC_NOTIFICATION = 2'd2;
    localparam logic [1:0] SRC_BATTERY      = 2'd3;

    localparam logic [7:0]  LUMA_R      = 8'd77;
    localparam logic [7:0]  LUMA_G      = 8'd150;
    localparam logic [7:0]  LUMA_B      = 8'd29;
    localparam logic [23:0] WHITE       = 24'h00ffffff;
    localparam logic [15:0] MIN_MS      = 16'd1000;
    // floor(v / 1000) == (v * RECIP_1000) >> RECIP_SHIFT for every 16-bit v
    localparam logic [16:0] RECIP_1000  = 17'd67109;
    localparam int          RECIP_SHIFT = 26;
    localparam logic [6:0]  STEADY_SECS = 7'd2;

    typedef struct packed {
        logic [2:0]  operation;
        logic [23:0] color;
        logic        flash_timed;
        logic [15:0] on_ms;
        logic [15:0] off_ms;
    } request_t;

    typedef struct packed {
        logic [7:0] lcd_brightness;
        logic       lcd_written;
        logic [7:0] button_brightness;
        logic       button_written;
        logic [7:0] led_red;
        logic [7:0] led_green;
        logic [7:0] led_blue;
        logic       blink;
        logic [6:0] lit_seconds;
        logic [6:0] dark_seconds;
        logic       pattern_written;
    } result_t;

    typedef struct packed {
        logic [23:0] color;
        logic        flash_timed;
        logic [15:0] on_ms;
        logic [15:0] off_ms;
    } light_entry_t;

    // classified request handed from front to back
    typedef struct packed {
        logic [7:0]   lcd_brightness;
        logic         lcd_written;
        logic [7:0]   button_brightness;
        logic         button_written;
        logic         lit;
        light_entry_t entry;
    } job_t;

    typedef struct packed {
        logic full;
        logic rd_valid;
    } queue_status_t;

endpackage

@@ rtl/core/nla_front.sv @@
`timescale 1ns / 1ps
// front end: luma, source store update and priority pick
// depends on nla_pkg
module nla_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              accept,
    input  nla_pkg::request_t request,
    output nla_pkg::job_t     job
);
    import nla_pkg::*;

    light_entry_t store_reg  [NUM_SOURCES];
    light_entry_t store_next [NUM_SOURCES];
    logic [23:0]  saved_battery_reg;
    logic [23:0]  saved_battery_next;
    logic [15:0]  luma_sum;
    logic [7:0]   luma;
    light_entry_t ev;

    assign ev.color       = request.color;
    assign ev.flash_timed = request.flash_timed;
    assign ev.on_ms       = request.on_ms;
    assign ev.off_ms      = request.off_ms;

    assign luma_sum = 16'(LUMA_R) * 16'(request.color[23:16])
                    + 16'(LUMA_G) * 16'(request.color[15:8])
                    + 16'(LUMA_B) * 16'(request.color[7:0]);
    assign luma = luma_sum[15:8];

    always_comb
    begin
        for (int i = 0; i < NUM_SOURCES; i++)
        begin
            store_next[i] = store_reg[i];
        end
        saved_battery_next = saved_battery_reg;
        unique case (request.operation)
            OP_BACKLIGHT:
            begin
                store_next[SRC_BATTERY].color = (luma != 8'd0) ? 24'd0 : saved_battery_reg;
            end
            OP_BUTTONS:
            begin
                store_next[SRC_BUTTONS]       = ev;
                store_next[SRC_BUTTONS].color = (luma != 8'd0) ? WHITE : 24'd0;
            end
            OP_NOTIFICATION: store_next[SRC_NOTIFICATION] = ev;
            OP_ATTENTION:    store_next[SRC_ATTENTION] = ev;
            OP_BATTERY:
            begin
                store_next[SRC_BATTERY] = ev;
                saved_battery_next      = ev.color;
            end
            default: ;
        endcase
    end

    always_comb
    begin
        job.lcd_written       = (request.operation == OP_BACKLIGHT);
        job.lcd_brightness    = job.lcd_written ? luma : 8'd0;
        job.button_written    = (request.operation == OP_BUTTONS);
        job.button_brightness = job.button_written ? luma : 8'd0;
        job.lit               = 1'b1;
        priority if (store_next[SRC_BUTTONS].color != 24'd0)
            job.entry = store_next[SRC_BUTTONS];
        else if (store_next[SRC_ATTENTION].color != 24'd0)
            job.entry = store_next[SRC_ATTENTION];
        else if (store_next[SRC_NOTIFICATION].color != 24'd0)
            job.entry = store_next[SRC_NOTIFICATION];
        else if (store_next[SRC_BATTERY].color != 24'd0)
            job.entry = store_next[SRC_BATTERY];
        else
        begin
            job.entry = store_next[SRC_BATTERY];
            job.lit   = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_SOURCES; i++)
            begin
                store_reg[i] <= '0;
            end
            saved_battery_reg <= '0;
        end
        else if (accept)
        begin
            for (int i = 0; i < NUM_SOURCES; i++)
            begin
                store_reg[i] <= store_next[i];
            end
            saved_battery_reg <= saved_battery_next;
        end
    end

endmodule

@@ rtl/core/nla_queue.sv @@
`timescale 1ns / 1ps
// short fifo of classified jobs between front and back
// depends on nla_pkg
module nla_queue #(
    parameter int DEPTH = 2
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   wr_en,
    input  nla_pkg::job_t          wr_data,
    input  logic                   rd_en,
    output nla_pkg::job_t          rd_data,
    output nla_pkg::queue_status_t status
);
    import nla_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    job_t             slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             do_wr;
    logic             do_rd;

    assign status.full     = (count_reg == CNT_W'(DEPTH));
    assign status.rd_valid = (count_reg != '0);
    assign rd_data         = slot_reg[rd_ptr_reg];
    assign do_wr           = wr_en && !status.full;
    assign do_rd           = rd_en && status.rd_valid;

    function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(DEPTH - 1)) ? '0 : PTR_W'(p + 1'b1);
    endfunction

    always_ff @(posedge clk)
    begin
        if (do_wr)
            slot_reg[wr_ptr_reg] <= wr_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_wr)
                wr_ptr_reg <= bump(wr_ptr_reg);
            if (do_rd)
                rd_ptr_reg <= bump(rd_ptr_reg);
            if (do_wr && !do_rd)
                count_reg <= CNT_W'(count_reg + 1'b1);
            else if (do_rd && !do_wr)
                count_reg <= CNT_W'(count_reg - 1'b1);
        end
    end

endmodule

@@ rtl/core/nla_back.sv @@
`timescale 1ns / 1ps
// back end: blink decision, breath times and output register
// depends on nla_pkg
module nla_back (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             job_valid,
    input  nla_pkg::job_t    job,
    output logic             job_take,
    input  logic             pop,
    output logic             empty,
    output nla_pkg::result_t result
);
    import nla_pkg::*;

    result_t     out_reg;
    result_t     out_next;
    logic        out_valid_reg;
    logic [7:0]  r;
    logic [7:0]  g;
    logic [7:0]  b;
    logic [7:0]  ref_level;
    logic        same_active;
    logic [15:0] on_ms;
    logic [15:0] off_ms;
    logic [15:0] on_clamped;
    logic [15:0] off_clamped;
    logic [32:0] on_prod;
    logic [32:0] off_prod;
    logic        do_blink;

    assign job_take = job_valid && (!out_valid_reg || pop);
    assign empty    = !out_valid_reg;
    assign result   = out_reg;

    assign r = job.entry.color[23:16];
    assign g = job.entry.color[15:8];
    assign b = job.entry.color[7:0];
    assign ref_level   = (r != 8'd0) ? r : ((g != 8'd0) ? g : b);
    assign same_active = (r == 8'd0 || r == ref_level)
                      && (g == 8'd0 || g == ref_level)
                      && (b == 8'd0 || b == ref_level);

    assign on_ms       = job.entry.flash_timed ? job.entry.on_ms : 16'd0;
    assign off_ms      = job.entry.flash_timed ? job.entry.off_ms : 16'd0;
    assign do_blink    = (on_ms != 16'd0) && (off_ms != 16'd0) && same_active;
    assign on_clamped  = (on_ms < MIN_MS) ? MIN_MS : on_ms;
    assign off_clamped = (off_ms < MIN_MS) ? MIN_MS : off_ms;
    // divide by 1000 through the reciprocal
    assign on_prod     = 33'(on_clamped) * 33'(RECIP_1000);
    assign off_prod    = 33'(off_clamped) * 33'(RECIP_1000);

    always_comb
    begin
        out_next.lcd_brightness    = job.lcd_brightness;
        out_next.lcd_written       = job.lcd_written;
        out_next.button_brightness = job.button_brightness;
        out_next.button_written    = job.button_written;
        if (!job.lit)
        begin
            out_next.led_red         = 8'd0;
            out_next.led_green       = 8'd0;
            out_next.led_blue        = 8'd0;
            out_next.blink           = 1'b0;
            out_next.lit_seconds     = STEADY_SECS;
            out_next.dark_seconds    = STEADY_SECS;
            out_next.pattern_written = 1'b0;
        end
        else
        begin
            out_next.led_red         = r;
            out_next.led_green       = g;
            out_next.led_blue        = b;
            out_next.blink           = do_blink;
            out_next.lit_seconds     = do_blink ? on_prod[RECIP_SHIFT+6:RECIP_SHIFT]
                                                : STEADY_SECS;
            out_next.dark_seconds    = do_blink ? off_prod[RECIP_SHIFT+6:RECIP_SHIFT]
                                                : STEADY_SECS;
            out_next.pattern_written = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (job_take)
            out_reg <= out_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (job_take)
            out_valid_reg <= 1'b1;
        else if (pop)
            out_valid_reg <= 1'b0;
    end

endmodule

@@ rtl/core/notification_led_arbiter.sv @@
`timescale 1ns / 1ps
// notification led arbiter: backlight/button luma and indicator led pick
// input channel push/full, result channel empty/pop
// light-update requests enter with push while full is low, one per cycle;
//   operation names the source, color/flash/on/off give its setting
// every request yields exactly one result, in request order
// the front end computes luma, updates the stored sources and picks the
//   highest-priority lit one in the cycle the request is taken
// a short job queue (QUEUE_DEPTH entries) parts front and back end
// the back end works out blink and breath seconds into an output register
// result path: a taken request's job goes through the queue and then into the
//   output register, where it shows (empty low) once that register is free
// throughput: one request per cycle while the receiver pops every cycle;
//   the output register and the queue each take one new job per cycle
// receiver stall: results wait in the output register, then the queue
//   fills and full rises; nothing is lost or dropped
// reset: every stored source and the saved battery colour go dark,
//   the queue and the output register are emptied
module notification_led_arbiter #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    output logic              full,
    input  nla_pkg::request_t request,
    output logic              empty,
    input  logic              pop,
    output nla_pkg::result_t  result
);
    import nla_pkg::*;

    logic          accept;
    job_t          front_job;
    job_t          queue_job;
    queue_status_t q_status;
    logic          job_take;

    // a request is taken only when the queue has room for its job
    assign full   = q_status.full;
    assign accept = push && !q_status.full;

    nla_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .accept  (accept),
        .request (request),
        .job     (front_job)
    );

    nla_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (accept),
        .wr_data (front_job),
        .rd_en   (job_take),
        .rd_data (queue_job),
        .status  (q_status)
    );

    // back end pulls a job whenever its output register is free or popped
    nla_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_valid (q_status.rd_valid),
        .job       (queue_job),
        .job_take  (job_take),
        .pop       (pop),
        .empty     (empty),
        .result    (result)
    );

endmodule

@@ bench/led_result_checker.sv @@
`timescale 1ns / 1ps
// checker for the notification led arbiter: watches the request and result channels,
// predicts each result from its own copy of the stored sources and compares
// depends on nla_pkg for the request and result types and the constants
module led_result_checker
    import nla_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     push,
    input  logic     full,
    input  request_t request,
    input  logic     empty,
    input  logic     pop,
    input  result_t  result,
    output int       mismatches,
    output int       waiting,
    output int       compared,
    output int       blinks
);

    light_entry_t source_copy[NUM_SOURCES];
    logic [23:0]  battery_copy;
    result_t      led_results_due[$];

    initial
    begin
        mismatches = 0;
        waiting    = 0;
        compared   = 0;
        blinks     = 0;
    end

    // applies one request to the copied state and returns the result it yields
    function automatic result_t predict_led(input request_t req);
        result_t      res;
        light_entry_t ev;
        light_entry_t pick;
        logic         found;
        int           lum;
        int           on_t;
        int           off_t;
        logic [7:0]   r;
        logic [7:0]   g;
        logic [7:0]   b;
        logic [7:0]   lead;
        res   = '0;
        ev    = '{color: req.color, flash_timed: req.flash_timed,
                  on_ms: req.on_ms, off_ms: req.off_ms};
        lum   = (int'(LUMA_R) * int'(req.color[23:16]) + int'(LUMA_G) * int'(req.color[15:8])
                 + int'(LUMA_B) * int'(req.color[7:0])) >> 8;
        case (req.operation)
            OP_BACKLIGHT:
            begin
                res.lcd_brightness = lum[7:0];
                res.lcd_written    = 1'b1;
                source_copy[SRC_BATTERY].color = (lum != 0) ? 24'd0 : battery_copy;
            end
            OP_BUTTONS:
            begin
                res.button_brightness = lum[7:0];
                res.button_written    = 1'b1;
                source_copy[SRC_BUTTONS]       = ev;
                source_copy[SRC_BUTTONS].color = (lum != 0) ? WHITE : 24'd0;
            end
            OP_NOTIFICATION: source_copy[SRC_NOTIFICATION] = ev;
            OP_ATTENTION:    source_copy[SRC_ATTENTION]    = ev;
            OP_BATTERY:
            begin
                source_copy[SRC_BATTERY] = ev;
                battery_copy             = req.color;
            end
            default: ;
        endcase

        // first lit source in priority order wins
        found = 1'b0;
        pick  = '0;
        for (int i = 0; i < NUM_SOURCES; i++)
        begin
            if (!found && source_copy[i].color != 24'd0)
            begin
                pick  = source_copy[i];
                found = 1'b1;
            end
        end

        res.lit_seconds  = STEADY_SECS;
        res.dark_seconds = STEADY_SECS;
        if (found)
        begin
            r     = pick.color[23:16];
            g     = pick.color[15:8];
            b     = pick.color[7:0];
            on_t  = pick.flash_timed ? int'(pick.on_ms) : 0;
            off_t = pick.flash_timed ? int'(pick.off_ms) : 0;
            lead  = (r != 0) ? r : ((g != 0) ? g : b);
            if (on_t != 0 && off_t != 0 && (r == 0 || r == lead) && (g == 0 || g == lead)
                && (b == 0 || b == lead))
            begin
                if (on_t < int'(MIN_MS))
                    on_t = int'(MIN_MS);
                if (off_t < int'(MIN_MS))
                    off_t = int'(MIN_MS);
                res.blink        = 1'b1;
                res.lit_seconds  = 7'(on_t / 1000);
                res.dark_seconds = 7'(off_t / 1000);
            end
            res.led_red         = r;
            res.led_green       = g;
            res.led_blue        = b;
            res.pattern_written = 1'b1;
        end
        return res;
    endfunction

    task automatic check_field(input string name, input logic [23:0] want,
                               input logic [23:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        result_t want;
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_SOURCES; i++)
                source_copy[i] = '0;
            battery_copy = '0;
            led_results_due.delete();
        end
        else
        begin
            if (push && !full)
                led_results_due.push_back(predict_led(request));
            if (pop && !empty)
            begin
                if (led_results_due.size() == 0)
                begin
                    $error("result with no request outstanding");
                    mismatches++;
                end
                else
                begin
                    want = led_results_due.pop_front();
                    compared++;
                    if (want.blink)
                        blinks++;
                    check_field("lcd_brightness", want.lcd_brightness, result.lcd_brightness);
                    check_field("lcd_written", want.lcd_written, result.lcd_written);
                    check_field("button_brightness", want.button_brightness,
                                result.button_brightness);
                    check_field("button_written", want.button_written, result.button_written);
                    check_field("led_red", want.led_red, result.led_red);
                    check_field("led_green", want.led_green, result.led_green);
                    check_field("led_blue", want.led_blue, result.led_blue);
                    check_field("blink", want.blink, result.blink);
                    check_field("lit_seconds", want.lit_seconds, result.lit_seconds);
                    check_field("dark_seconds", want.dark_seconds, result.dark_seconds);
                    check_field("pattern_written", want.pattern_written,
                                result.pattern_written);
                end
            end
        end
        waiting = led_results_due.size();
    end

endmodule

@@ bench/tb.sv @@
`timescale 1ns / 1ps
// testbench top for the notification led arbiter: clock, reset, request
// stimulus, random receiver stalls and the verdict
// depends on nla_pkg, notification_led_arbiter and led_result_checker
module tb;
    import nla_pkg::*;

    localparam int RANDOM_REQUESTS = 1700;
    localparam int CYCLE_LIMIT     = 200000;
    localparam int IDLE_PERCENT    = 37;

    logic     clk     = 1'b0;
    logic     rst_n   = 1'b0;
    logic     push    = 1'b0;
    logic     pop     = 1'b0;
    request_t request = '0;
    logic     full;
    logic     empty;
    result_t  result;

    // calm turns off random idling of the receiver for a stretch (the sender uses quiet)
    logic     calm    = 1'b0;
    int       cycles  = 0;
    int       sent    = 0;
    int       mismatches;
    int       waiting;
    int       compared;
    int       blinks;

    notification_led_arbiter u_top (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .full    (full),
        .request (request),
        .empty   (empty),
        .pop     (pop),
        .result  (result)
    );

    led_result_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .request    (request),
        .empty      (empty),
        .pop        (pop),
        .result     (result),
        .mismatches (mismatches),
        .waiting    (waiting),
        .compared   (compared),
        .blinks     (blinks)
    );

    always #2 clk = ~clk;

    // watchdog: a hung handshake ends the run as a failure
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // receiver: pops at random, or every cycle during the calm stretch
    always @(posedge clk)
    begin
        if (!rst_n)
            pop <= 1'b0;
        else
            pop <= calm ? 1'b1 : ($urandom_range(99) >= IDLE_PERCENT);
    end

    // offers one request; returns right after the edge that accepted it, so the
    // next call may keep push high without a gap
    task automatic send_request(input request_t req, input logic quiet);
        while (!quiet && $urandom_range(99) < IDLE_PERCENT)
        begin
            push <= 1'b0;
            @(posedge clk);
        end
        push    <= 1'b1;
        request <= req;
        do
            @(posedge clk);
        while (full);
        sent++;
    endtask

    task automatic send_fields(input logic [2:0] op, input logic [23:0] color,
                               input logic flash, input logic [15:0] on_ms,
                               input logic [15:0] off_ms);
        request_t req;
        req = '{operation: op, color: color, flash_timed: flash, on_ms: on_ms,
                off_ms: off_ms};
        send_request(req, 1'b0);
    endtask

    // colors lean toward dark, grey-like (equal nonzero components) and extremes,
    // so that blinking and priority hand-over both show up often
    function automatic logic [23:0] pick_color();
        logic [7:0] level;
        logic [2:0] mask;
        level = 8'($urandom_range(1, 255));
        mask  = 3'($urandom_range(1, 7));
        case ($urandom_range(9))
            0, 1: return 24'd0;
            2, 3: return {mask[2] ? level : 8'd0, mask[1] ? level : 8'd0,
                          mask[0] ? level : 8'd0};
            4:    return {mask[2] ? 8'hff : 8'd0, mask[1] ? 8'h01 : 8'd0,
                          mask[0] ? 8'hff : 8'd0};
            5:    return WHITE;
            default: return 24'($urandom);
        endcase
    endfunction

    // times cluster around zero, the one-second floor and saturation
    function automatic logic [15:0] pick_ms();
        case ($urandom_range(7))
            0: return 16'd0;
            1: return 16'($urandom_range(1, 999));
            2: return 16'($urandom_range(999, 1001));
            3: return 16'hffff;
            default: return 16'($urandom_range(0, 65535));
        endcase
    endfunction

    function automatic request_t random_request();
        request_t   req;
        int         roll;
        roll = $urandom_range(99);
        if (roll < 15)
            req.operation = OP_BACKLIGHT;
        else if (roll < 25)
            req.operation = OP_BUTTONS;
        else if (roll < 50)
            req.operation = OP_NOTIFICATION;
        else if (roll < 70)
            req.operation = OP_ATTENTION;
        else if (roll < 95)
            req.operation = OP_BATTERY;
        else
            req.operation = 3'($urandom_range(5, 7));
        req.color       = pick_color();
        // lit buttons hide every other source, so keep them dark half the time
        if (req.operation == OP_BUTTONS && $urandom_range(1) == 0)
            req.color = 24'd0;
        req.flash_timed = ($urandom_range(3) != 0);
        req.on_ms       = pick_ms();
        req.off_ms      = pick_ms();
        return req;
    endfunction

    initial
    begin
        logic quiet;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty state, an unknown source kind with everything dark
        send_fields(3'd5, 24'd0, 1'b0, 16'd0, 16'd0);
        // battery alone, equal components, short on time raised to one second
        send_fields(OP_BATTERY, 24'h00ff00, 1'b1, 16'd500, 16'hffff);
        // mixed components never blink
        send_fields(OP_BATTERY, 24'h102030, 1'b1, 16'd2000, 16'd2000);
        // a lit display hides the battery, a dark one brings back the saved color
        send_fields(OP_BACKLIGHT, 24'hffffff, 1'b0, 16'd0, 16'd0);
        send_fields(OP_BACKLIGHT, 24'h000000, 1'b1, 16'hffff, 16'hffff);
        send_fields(OP_BATTERY, 24'h505000, 1'b1, 16'd1000, 16'd999);
        // nonzero color whose luma rounds to zero counts as a dark display
        send_fields(OP_BACKLIGHT, 24'h000001, 1'b0, 16'd0, 16'd0);
        // notification: one time zero, then flashing off, then a blinking setting
        send_fields(OP_NOTIFICATION, 24'hff00ff, 1'b1, 16'd1500, 16'd0);
        send_fields(OP_NOTIFICATION, 24'hff00ff, 1'b0, 16'd3000, 16'd3000);
        send_fields(OP_NOTIFICATION, 24'h800080, 1'b1, 16'd2999, 16'd1000);
        // attention outranks notification, saturated times
        send_fields(OP_ATTENTION, 24'h0000ff, 1'b1, 16'hffff, 16'hffff);
        // buttons with luma zero stay dark, then bright buttons become white
        send_fields(OP_BUTTONS, 24'h000002, 1'b1, 16'd1, 16'd1);
        send_fields(OP_BUTTONS, 24'h000100, 1'b0, 16'd0, 16'd0);
        send_fields(OP_BUTTONS, 24'h123456, 1'b1, 16'd999, 16'd1);
        send_fields(OP_BUTTONS, 24'hffffff, 1'b1, 16'd65000, 16'd0);
        // unknown kinds leave the stored sources alone
        send_fields(3'd6, 24'hffffff, 1'b1, 16'hffff, 16'hffff);
        send_fields(3'd7, 24'h5a5a5a, 1'b1, 16'd1234, 16'd4321);
        // peel sources off in priority order until the led goes dark
        send_fields(OP_BUTTONS, 24'd0, 1'b0, 16'd0, 16'd0);
        send_fields(OP_ATTENTION, 24'd0, 1'b1, 16'd1000, 16'd1000);
        send_fields(OP_NOTIFICATION, 24'd0, 1'b0, 16'd0, 16'd0);
        send_fields(OP_BATTERY, 24'd0, 1'b0, 16'd0, 16'd0);
        send_fields(OP_BACKLIGHT, 24'h808080, 1'b0, 16'd0, 16'd0);

        // random part, with a stretch at full rate on both sides
        for (int n = 0; n < RANDOM_REQUESTS; n++)
        begin
            quiet = (n >= 700 && n < 1000);
            calm <= quiet;
            send_request(random_request(), quiet);
        end
        push <= 1'b0;
        calm <= 1'b0;

        // drain, then let anything stray show up before the verdict
        while (waiting != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);

        $display("sent %0d light-update requests across all source kinds, backlight and",
                 sent);
        $display("button luma, priority hand-over and blinking; %0d results compared, %0d blinking",
                 compared, blinks);
        if (mismatches == 0 && waiting == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
